### hw/rtl/nrucpr_pkg.sv
// Shared types and constants for the clock page replacer.
`default_nettype none

package nrucpr_pkg;

  // Command codes of an input item.
  localparam logic CMD_PRELOAD   = 1'b0;
  localparam logic CMD_REFERENCE = 1'b1;

  // Width of the saturating fault counter and its ceiling.
  localparam int unsigned FAULT_W = 32;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Width of the frame limit register.
  localparam int unsigned LIMIT_W = 5;

  // Width of page numbers on the ports.
  localparam int unsigned PORT_PAGE_W = 16;

  // Width of the resident count on the ports.
  localparam int unsigned RESIDENT_W = 5;

  // Per-frame control from the sequencer to one cell of the ring.
  typedef struct packed {
    logic load;       // write a new page with referenced set
    logic shift;      // take the entry of the left neighbor
    logic touch;      // set the referenced bit
    logic touch_mod;  // set the modified bit
    logic clr_ref;    // clear the referenced bit
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/nrucpr_cell.sv
// One frame of the replacement ring: tag, referenced and modified bits.
`default_nettype none

module nrucpr_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire nrucpr_pkg::cell_ctl_t  ctl,
  input  wire logic [PAGE_BITS-1:0]   key,
  input  wire logic                   new_mod,
  input  wire logic [PAGE_BITS-1:0]   left_page,
  input  wire logic                   left_ref,
  input  wire logic                   left_mod,
  output logic [PAGE_BITS-1:0]        page,
  output logic                        ref_bit,
  output logic                        mod_bit,
  output logic                        match
);

  logic [PAGE_BITS-1:0] page_r;
  logic                 ref_r;
  logic                 mod_r;

  // A new page is written from the lookup key; a shift takes the neighbor's entry.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      page_r <= key;
      ref_r  <= 1'b1;
      mod_r  <= new_mod;
    end else if (ctl.shift) begin
      page_r <= left_page;
      ref_r  <= left_ref;
      mod_r  <= left_mod;
    end else begin
      if (ctl.touch) begin
        ref_r <= 1'b1;
      end
      if (ctl.touch_mod) begin
        mod_r <= 1'b1;
      end
      if (ctl.clr_ref) begin
        ref_r <= 1'b0;
      end
    end
  end

  // Tag compare for the parallel lookup.
  assign match   = (page_r == key);
  assign page    = page_r;
  assign ref_bit = ref_r;
  assign mod_bit = mod_r;

endmodule

`default_nettype wire

### hw/rtl/nru_clock_page_replacer_unit.sv
// Top level of the not-recently-used clock page replacer.
`default_nettype none

// An item is taken when start is high and busy is low. A hit, a preload or a
// fault that finds a free frame registers its result on the out_ ports from the
// lookup state, and the next item can be taken while that result is shown. A
// fault into a full ring sweeps the ring from the hand, one frame per cycle, and
// visits at most 4n + 1 frames, n being the resident count, victim included.
// out_valid is high for exactly one cycle per item and cannot be held off. The
// frame limit is written through cfg_valid/cfg_data (cfg_ready is always high);
// the user must write it only while idle, which the block does not enforce.
module nru_clock_page_replacer_unit #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Command channel.
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_cmd,
  input  wire logic [nrucpr_pkg::PORT_PAGE_W-1:0]   in_page_number,
  input  wire logic                                 in_is_write,
  // Result channel.
  output logic                                      out_valid,
  output logic                                      out_accepted,
  output logic                                      out_hit,
  output logic                                      out_fault,
  output logic                                      out_evicted,
  output logic [nrucpr_pkg::PORT_PAGE_W-1:0]        out_victim_page,
  output logic                                      out_victim_dirty,
  output logic [nrucpr_pkg::FAULT_W-1:0]            out_fault_total,
  output logic [nrucpr_pkg::RESIDENT_W-1:0]         out_resident_count,
  // Frame limit register.
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [nrucpr_pkg::LIMIT_W-1:0]       cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP
  } state_t;

  state_t                            state_r;
  logic [PAGE_BITS-1:0]              key_r;
  logic                              cmd_r;
  logic                              wr_r;
  logic [IDX_W-1:0]                  hand_r;
  logic [CNT_W-1:0]                  occ_r;
  logic [nrucpr_pkg::FAULT_W-1:0]    fault_cnt_r;
  logic [1:0]                        pass_r;
  logic [CNT_W-1:0]                  sweep_cnt_r;
  logic [nrucpr_pkg::LIMIT_W-1:0]    limit_r;
  logic                              out_valid_r;
  logic                              out_accepted_r;
  logic                              out_hit_r;
  logic                              out_fault_r;
  logic                              out_evicted_r;
  logic [nrucpr_pkg::PORT_PAGE_W-1:0] out_victim_page_r;
  logic                              out_victim_dirty_r;

  // Cell array signals.
  nrucpr_pkg::cell_ctl_t             ctl     [MAX_FRAMES];
  logic [PAGE_BITS-1:0]              page_q  [MAX_FRAMES];
  logic                              ref_q   [MAX_FRAMES];
  logic                              mod_q   [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]             match_q;
  logic [MAX_FRAMES-1:0]             hit_vec;

  logic                              hit_any;
  logic [IDX_W-1:0]                  hit_idx;
  logic [CNT_W-1:0]                  limit;
  logic                              full;
  logic                              key_nonzero;
  logic [IDX_W-1:0]                  ins_pos;
  logic [IDX_W-1:0]                  hand_next;
  logic                              sweep_hit;
  logic                              do_insert;
  logic                              do_touch;

  // Row of frame cells; cells above the insert position take their left neighbor's entry on an insert.
  for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_cell
    if (j == 0) begin : g_first
      nrucpr_cell #(
        .PAGE_BITS (PAGE_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl[j]),
        .key       (key_r),
        .new_mod   (wr_r),
        .left_page ('0),
        .left_ref  (1'b0),
        .left_mod  (1'b0),
        .page      (page_q[j]),
        .ref_bit   (ref_q[j]),
        .mod_bit   (mod_q[j]),
        .match     (match_q[j])
      );
    end else begin : g_rest
      nrucpr_cell #(
        .PAGE_BITS (PAGE_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl[j]),
        .key       (key_r),
        .new_mod   (wr_r),
        .left_page (page_q[j-1]),
        .left_ref  (ref_q[j-1]),
        .left_mod  (mod_q[j-1]),
        .page      (page_q[j]),
        .ref_bit   (ref_q[j]),
        .mod_bit   (mod_q[j]),
        .match     (match_q[j])
      );
    end
    // Only occupied frames take part in the lookup.
    assign hit_vec[j] = match_q[j] && (CNT_W'(j) < occ_r);
  end

  // Lowest matching frame wins; tags are unique, so at most one matches.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
  end

  // Frame limit clamped to one through MAX_FRAMES.
  always_comb begin
    if (limit_r == '0) begin
      limit = CNT_W'(1);
    end else if (32'(limit_r) > 32'(MAX_FRAMES)) begin
      limit = CNT_W'(MAX_FRAMES);
    end else begin
      limit = CNT_W'(limit_r);
    end
  end

  assign full        = (occ_r >= limit);
  assign key_nonzero = (key_r != '0);
  assign ins_pos     = (occ_r == '0) ? '0 : hand_r;
  assign hand_next   = (CNT_W'(hand_r) == occ_r - CNT_W'(1)) ? '0 : hand_r + IDX_W'(1);
  assign sweep_hit   = ({ref_q[hand_r], mod_q[hand_r]} == pass_r);

  // Decision taken in the lookup cycle.
  always_comb begin
    do_insert = 1'b0;
    do_touch  = 1'b0;
    if (state_r == S_LOOK) begin
      if (cmd_r == nrucpr_pkg::CMD_PRELOAD) begin
        do_insert = !hit_any && key_nonzero && !full;
      end else begin
        do_touch  = hit_any;
        do_insert = !hit_any && !full;
      end
    end
  end

  // Per-cell controls for insert, touch and the sweep.
  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      ctl[j] = '0;
      if (do_insert) begin
        ctl[j].load  = (IDX_W'(j) == ins_pos);
        ctl[j].shift = (IDX_W'(j) > ins_pos) && (CNT_W'(j) <= occ_r);
      end
      if (do_touch && IDX_W'(j) == hit_idx) begin
        ctl[j].touch     = 1'b1;
        ctl[j].touch_mod = wr_r;
      end
      if (state_r == S_SWEEP && IDX_W'(j) == hand_r) begin
        ctl[j].load    = sweep_hit;
        ctl[j].clr_ref = !sweep_hit;
      end
    end
  end

  // Sequencer, ring bookkeeping and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      key_r              <= '0;
      cmd_r              <= nrucpr_pkg::CMD_PRELOAD;
      wr_r               <= 1'b0;
      hand_r             <= '0;
      occ_r              <= '0;
      fault_cnt_r        <= '0;
      pass_r             <= '0;
      sweep_cnt_r        <= '0;
      limit_r            <= nrucpr_pkg::LIMIT_W'(16);
      out_valid_r        <= 1'b0;
      out_accepted_r     <= 1'b0;
      out_hit_r          <= 1'b0;
      out_fault_r        <= 1'b0;
      out_evicted_r      <= 1'b0;
      out_victim_page_r  <= '0;
      out_victim_dirty_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            key_r   <= PAGE_BITS'(in_page_number);
            cmd_r   <= in_cmd;
            wr_r    <= in_is_write;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          out_hit_r          <= hit_any;
          out_evicted_r      <= 1'b0;
          out_victim_page_r  <= '0;
          out_victim_dirty_r <= 1'b0;
          if (do_insert) begin
            occ_r  <= occ_r + CNT_W'(1);
            hand_r <= (occ_r == '0) ? '0 : ins_pos + IDX_W'(1);
          end
          if (cmd_r == nrucpr_pkg::CMD_PRELOAD) begin
            out_accepted_r <= do_insert;
            out_fault_r    <= 1'b0;
            out_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end else begin
            out_accepted_r <= 1'b1;
            out_fault_r    <= !hit_any;
            if (!hit_any && fault_cnt_r != nrucpr_pkg::FAULT_MAX) begin
              fault_cnt_r <= fault_cnt_r + nrucpr_pkg::FAULT_W'(1);
            end
            if (!hit_any && full) begin
              pass_r      <= '0;
              sweep_cnt_r <= '0;
              out_valid_r <= 1'b0;
              state_r     <= S_SWEEP;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_SWEEP: begin
          hand_r <= hand_next;
          if (sweep_hit) begin
            out_evicted_r      <= 1'b1;
            out_victim_page_r  <= nrucpr_pkg::PORT_PAGE_W'(page_q[hand_r]);
            out_victim_dirty_r <= mod_q[hand_r];
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end else if (sweep_cnt_r == occ_r - CNT_W'(1)) begin
            // One full lap without a match: look for the next class.
            out_valid_r <= 1'b0;
            sweep_cnt_r <= '0;
            pass_r      <= pass_r + 2'd1;
          end else begin
            out_valid_r <= 1'b0;
            sweep_cnt_r <= sweep_cnt_r + CNT_W'(1);
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_accepted       = out_accepted_r;
  assign out_hit            = out_hit_r;
  assign out_fault          = out_fault_r;
  assign out_evicted        = out_evicted_r;
  assign out_victim_page    = out_victim_page_r;
  assign out_victim_dirty   = out_victim_dirty_r;
  assign out_fault_total    = fault_cnt_r;
  assign out_resident_count = nrucpr_pkg::RESIDENT_W'(occ_r);

  // A result is only shown once the sequencer is back to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Resident tags are unique, so the lookup never finds two frames.
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |-> $onehot0(hit_vec))
    else $error("page resident in more than one frame");

  // An eviction only comes from a faulting reference.
  a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (out_fault && out_accepted && !out_hit))
    else $error("eviction without a fault");

  // The hand stays inside the occupied part of the ring while sweeping.
  a_hand_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> (CNT_W'(hand_r) < occ_r))
    else $error("sweep hand outside the ring");

  // Occupancy never exceeds the number of frames.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(MAX_FRAMES))
    else $error("occupancy above frame count");

endmodule

`default_nettype wire
